// ----- sv/dasc_pkg.sv -----
// Shared types, codes and angle arithmetic for the dome azimuth slew controller.
package dasc_pkg;

  // Angles are centidegrees, 0..35999, wrapping at one full turn.
  localparam int unsigned AngleW = 16;
  localparam logic [AngleW-1:0] FULL_TURN = 16'd36000;
  localparam logic [AngleW-1:0] HALF_TURN = 16'd18000;
  localparam logic signed [AngleW:0] FullTurnS = 17'sd36000;
  localparam logic signed [AngleW:0] HalfTurnS = 17'sd18000;

  // Configuration port geometry: eight 32-bit registers at 4-byte spacing.
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned PaddrW = RegIdxW + 2;
  localparam int unsigned PdataW = 32;

  // Capability mask bit positions.
  localparam int unsigned CAP_FIND_HOME = 0;
  localparam int unsigned CAP_PARK = 1;
  localparam int unsigned CAP_SET_PARK = 2;
  localparam int unsigned CAP_SET_AZ = 3;
  localparam int unsigned CAP_SYNC = 4;

  // Request codes.
  typedef enum logic [3:0] {
    REQ_TICK      = 4'd0,
    REQ_SLEW_TO   = 4'd1,
    REQ_FIND_HOME = 4'd2,
    REQ_PARK      = 4'd3,
    REQ_SET_PARK  = 4'd4,
    REQ_SYNC      = 4'd5,
    REQ_ABORT     = 4'd6,
    REQ_ENCODER   = 4'd7,
    REQ_QUERY     = 4'd8
  } req_code_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_NOT_IMPL = 2'd2
  } status_t;

  // Register indexes on the configuration port.
  typedef enum logic [RegIdxW-1:0] {
    REG_DEADBAND     = 3'd0,
    REG_SLOW_RANGE   = 3'd1,
    REG_SLOW_SPEED   = 3'd2,
    REG_FAST_SPEED   = 3'd3,
    REG_SIM_STEP     = 3'd4,
    REG_HOME_DEGREES = 3'd5,
    REG_EXT_ENCODER  = 3'd6,
    REG_CAP_MASK     = 3'd7
  } reg_idx_t;

  // Request payload.
  typedef struct packed {
    logic [3:0]        req_type;
    logic [AngleW-1:0] azimuth_value;
  } req_item_t;

  // Result payload.
  typedef struct packed {
    logic [1:0]        status;
    logic              slewing;
    logic              motor_on;
    logic [7:0]        motor_speed;
    logic              motor_ccw;
    logic [AngleW-1:0] azimuth_out;
    logic              at_home;
    logic              at_park;
  } res_item_t;

  // Configuration as seen by the datapath; home_cd is home in centidegrees, wrapped.
  typedef struct packed {
    logic [14:0]       deadband;
    logic [14:0]       slow_range;
    logic [7:0]        slow_speed;
    logic [7:0]        fast_speed;
    logic [14:0]       sim_step;
    logic [8:0]        home_degrees;
    logic              external_encoder;
    logic [4:0]        capability_mask;
    logic [AngleW-1:0] home_cd;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    deadband:         15'd100,
    slow_range:       15'd1000,
    slow_speed:       8'd64,
    fast_speed:       8'd255,
    sim_step:         15'd100,
    home_degrees:     9'd0,
    external_encoder: 1'b0,
    capability_mask:  5'd31,
    home_cd:          16'd0
  };

  // Stage record handed from the execute stage to the report stage.
  typedef struct packed {
    logic [1:0]        status;
    logic              slewing;
    logic              motor_on;
    logic [7:0]        motor_speed;
    logic              motor_ccw;
    logic [AngleW-1:0] position;
    logic [AngleW-1:0] sync_offset;
    logic [AngleW-1:0] park_cd;
  } stage_t;

  // (a + b) mod one turn, both operands already in range.
  function automatic logic [AngleW-1:0] angle_add(input logic [AngleW-1:0] a,
                                                  input logic [AngleW-1:0] b);
    logic [AngleW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, FULL_TURN}) s = s - {1'b0, FULL_TURN};
    return s[AngleW-1:0];
  endfunction

  // (a - b) mod one turn, both operands already in range.
  function automatic logic [AngleW-1:0] angle_sub(input logic [AngleW-1:0] a,
                                                  input logic [AngleW-1:0] b);
    logic [AngleW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[AngleW]) d = d + {1'b0, FULL_TURN};
    return d[AngleW-1:0];
  endfunction

  // Shortest signed delta from cur to tgt, -18000..17999.
  function automatic logic signed [AngleW-1:0] short_delta(input logic [AngleW-1:0] tgt,
                                                           input logic [AngleW-1:0] cur);
    logic signed [AngleW:0] d;
    d = $signed({1'b0, tgt}) - $signed({1'b0, cur});
    if (d >= HalfTurnS) d = d - FullTurnS;
    else if (d < -HalfTurnS) d = d + FullTurnS;
    return $signed(d[AngleW-1:0]);
  endfunction

  // Magnitude of a shortest delta; never above a half turn.
  function automatic logic [14:0] angle_mag(input logic signed [AngleW-1:0] d);
    logic signed [AngleW-1:0] m;
    m = d[AngleW-1] ? -d : d;
    return m[14:0];
  endfunction

endpackage

// ----- sv/dasc_if.sv -----
// Request and result channel interfaces with valid/ready handshakes.
interface dasc_req_if import dasc_pkg::*;;
  logic      valid;
  logic      ready;
  req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface dasc_res_if import dasc_pkg::*;;
  logic      valid;
  logic      ready;
  res_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ----- sv/dasc_cfg.sv -----
// APB-style configuration register file for the slew controller.
module dasc_cfg import dasc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t    reg_idx;
  logic        wr_en;
  logic [15:0] home_prod;
  logic [15:0] home_cd_next;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PaddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  // Home in centidegrees, wrapped once; at most 511 degrees comes in.
  always_comb begin
    home_prod    = 16'(pwdata[8:0]) * 16'd100;
    home_cd_next = (home_prod >= FULL_TURN) ? home_prod - FULL_TURN : home_prod;
  end

  // Register writes on the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEADBAND:     cfg.deadband         <= pwdata[14:0];
        REG_SLOW_RANGE:   cfg.slow_range       <= pwdata[14:0];
        REG_SLOW_SPEED:   cfg.slow_speed       <= pwdata[7:0];
        REG_FAST_SPEED:   cfg.fast_speed       <= pwdata[7:0];
        REG_SIM_STEP:     cfg.sim_step         <= pwdata[14:0];
        REG_HOME_DEGREES: begin
          cfg.home_degrees <= pwdata[8:0];
          cfg.home_cd      <= home_cd_next;
        end
        REG_EXT_ENCODER:  cfg.external_encoder <= pwdata[0];
        REG_CAP_MASK:     cfg.capability_mask  <= pwdata[4:0];
        default:          ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      REG_DEADBAND:     prdata = PdataW'(cfg.deadband);
      REG_SLOW_RANGE:   prdata = PdataW'(cfg.slow_range);
      REG_SLOW_SPEED:   prdata = PdataW'(cfg.slow_speed);
      REG_FAST_SPEED:   prdata = PdataW'(cfg.fast_speed);
      REG_SIM_STEP:     prdata = PdataW'(cfg.sim_step);
      REG_HOME_DEGREES: prdata = PdataW'(cfg.home_degrees);
      REG_EXT_ENCODER:  prdata = PdataW'(cfg.external_encoder);
      REG_CAP_MASK:     prdata = PdataW'(cfg.capability_mask);
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- sv/dasc_exec.sv -----
// Input register, dome state and request execution stage.
module dasc_exec import dasc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  req_item_t in_item,
  output logic      s1_valid,
  output stage_t    s1,
  input  logic      s1_take
);

  // Reciprocal of 100 for a quotient of a value below one turn.
  localparam logic [12:0] RecipHundred = 13'd5243;
  localparam int unsigned RecipShift = 19;

  logic      in_full;
  req_item_t in_reg;
  logic      s1_load;

  logic [AngleW-1:0] position, position_next;
  logic [AngleW-1:0] target, target_next;
  logic [AngleW-1:0] sync_offset, sync_offset_next;
  logic [AngleW-1:0] park_cd, park_cd_next;
  logic              slew_active, slew_active_next;
  stage_t            s1_next;

  logic                     az_ok;
  logic signed [AngleW-1:0] tick_delta;
  logic [14:0]              tick_mag;
  logic [14:0]              tick_step;
  logic [AngleW-1:0]        slew_user;
  logic [AngleW-1:0]        slew_tgt;
  logic                     slew_near;
  logic                     do_slew;
  logic [AngleW-1:0]        user_az;
  logic [27:0]              park_prod;
  logic [8:0]               park_deg;
  status_t                  st;
  logic                     mon;
  logic [7:0]               spd;
  logic                     ccw;

  // Handshake: the input register drains into the stage register.
  assign s1_load  = in_full && (!s1_valid || s1_take);
  assign in_ready = !in_full || s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_item;
    end
  end

  // Operands for the request decode; az_ok is shared by several requests.
  always_comb begin
    az_ok      = in_reg.azimuth_value < FULL_TURN;
    tick_delta = short_delta(target, position);
    tick_mag   = angle_mag(tick_delta);
    tick_step  = (tick_mag < cfg.sim_step) ? tick_mag : cfg.sim_step;
    user_az    = angle_add(position, sync_offset);
    park_prod  = 28'(user_az) * 28'(RecipHundred);
    park_deg   = park_prod[RecipShift+8:RecipShift];
  end

  // Slew source: requested azimuth, home or park, mapped into the mechanical frame.
  always_comb begin
    case (in_reg.req_type)
      REQ_FIND_HOME: slew_user = cfg.home_cd;
      REQ_PARK:      slew_user = park_cd;
      default:       slew_user = in_reg.azimuth_value;
    endcase
    slew_tgt  = angle_sub(slew_user, sync_offset);
    slew_near = angle_mag(short_delta(slew_tgt, position)) <= cfg.deadband;
  end

  // Request decode and next state.
  always_comb begin
    position_next    = position;
    target_next      = target;
    sync_offset_next = sync_offset;
    park_cd_next     = park_cd;
    slew_active_next = slew_active;
    st               = STATUS_OK;
    mon              = 1'b0;
    spd              = '0;
    ccw              = 1'b0;
    do_slew          = 1'b0;

    unique case (in_reg.req_type)
      REQ_TICK: begin
        if (slew_active) begin
          if (tick_mag <= cfg.deadband) begin
            position_next    = target;
            slew_active_next = 1'b0;
          end else begin
            mon = 1'b1;
            spd = (tick_mag <= cfg.slow_range) ? cfg.slow_speed : cfg.fast_speed;
            ccw = tick_delta[AngleW-1];
            if (!cfg.external_encoder) begin
              position_next = tick_delta[AngleW-1] ?
                              angle_sub(position, AngleW'(tick_step)) :
                              angle_add(position, AngleW'(tick_step));
            end
          end
        end
      end
      REQ_SLEW_TO: begin
        if (!az_ok) st = STATUS_INVALID;
        else if (!cfg.capability_mask[CAP_SET_AZ]) st = STATUS_NOT_IMPL;
        else do_slew = 1'b1;
      end
      REQ_FIND_HOME: begin
        if (!cfg.capability_mask[CAP_FIND_HOME]) st = STATUS_NOT_IMPL;
        else do_slew = 1'b1;
      end
      REQ_PARK: begin
        if (!cfg.capability_mask[CAP_PARK]) st = STATUS_NOT_IMPL;
        else do_slew = 1'b1;
      end
      REQ_SET_PARK: begin
        // Park is kept in whole degrees, truncated.
        if (!cfg.capability_mask[CAP_SET_PARK]) st = STATUS_NOT_IMPL;
        else park_cd_next = 16'(park_deg) * 16'd100;
      end
      REQ_SYNC: begin
        if (!az_ok) st = STATUS_INVALID;
        else if (!cfg.capability_mask[CAP_SYNC]) st = STATUS_NOT_IMPL;
        else sync_offset_next = angle_sub(in_reg.azimuth_value, position);
      end
      REQ_ABORT: begin
        slew_active_next = 1'b0;
      end
      REQ_ENCODER: begin
        if (!az_ok) st = STATUS_INVALID;
        else if (cfg.external_encoder) position_next = in_reg.azimuth_value;
      end
      REQ_QUERY: ;
      default: st = STATUS_NOT_IMPL;
    endcase

    // A new slew replaces any running one; already close means snap and stop.
    if (do_slew) begin
      target_next = slew_tgt;
      if (slew_near) begin
        position_next    = slew_tgt;
        slew_active_next = 1'b0;
      end else begin
        slew_active_next = 1'b1;
      end
    end

    s1_next.status      = st;
    s1_next.slewing     = slew_active_next;
    s1_next.motor_on    = mon;
    s1_next.motor_speed = spd;
    s1_next.motor_ccw   = ccw;
    s1_next.position    = position_next;
    s1_next.sync_offset = sync_offset_next;
    s1_next.park_cd     = park_cd_next;
  end

  // State and stage register update once per executed request.
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      target      <= '0;
      sync_offset <= '0;
      park_cd     <= '0;
      slew_active <= 1'b0;
      s1_valid    <= 1'b0;
    end else begin
      if (s1_load) begin
        position    <= position_next;
        target      <= target_next;
        sync_offset <= sync_offset_next;
        park_cd     <= park_cd_next;
        slew_active <= slew_active_next;
        s1_valid    <= 1'b1;
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= s1_next;
    end
  end

endmodule

// ----- sv/dasc_report.sv -----
// Report stage: user-frame azimuth, home and park tests, and the result register.
module dasc_report import dasc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      s1_valid,
  input  stage_t    s1,
  output logic      s1_take,
  output logic      out_valid,
  input  logic      out_ready,
  output res_item_t out_item
);

  res_item_t out_next;
  logic [AngleW-1:0] home_mech;
  logic [AngleW-1:0] park_mech;

  assign s1_take = s1_valid && (!out_valid || out_ready);

  // Home and park are user-frame angles; compare them in the mechanical frame.
  always_comb begin
    home_mech = angle_sub(cfg.home_cd, s1.sync_offset);
    park_mech = angle_sub(s1.park_cd, s1.sync_offset);

    out_next.status      = s1.status;
    out_next.slewing     = s1.slewing;
    out_next.motor_on    = s1.motor_on;
    out_next.motor_speed = s1.motor_speed;
    out_next.motor_ccw   = s1.motor_ccw;
    out_next.azimuth_out = angle_add(s1.position, s1.sync_offset);
    out_next.at_home     = angle_mag(short_delta(home_mech, s1.position)) <= cfg.deadband;
    out_next.at_park     = angle_mag(short_delta(park_mech, s1.position)) <= cfg.deadband;
  end

  // Result register holds until the receiver takes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_item <= out_next;
    end
  end

endmodule

// ----- sv/dome_azimuth_slew_controller_core.sv -----
// Top level of the dome azimuth slew controller.
//
// Channels: request (sink) carries req_type and azimuth_value; result (source)
// carries one result item per request, in request order. Both use valid/ready;
// a transfer happens on a rising edge with valid and ready high. Registers are
// written through the APB-style port at byte address 4*index; pready is always
// high and reads return the register value.
//
// Pipeline: a request taken into the input register passes through the execute
// stage with the dome state, then the result register, before its result is valid.
// Throughput: one request per cycle unless the receiver stalls; the execute
// stage updates position, target, sync offset, park and slew state in the same
// cycle that it reads them, so consecutive ticks chain without a gap.
//
// Reset (rst, synchronous, active high) empties all stages, clears the dome
// state and loads the register defaults. When the receiver stalls, the result
// register holds its item; the stage and input registers keep filling, and
// request.ready drops only once all three are occupied.
module dome_azimuth_slew_controller_core import dasc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  dasc_req_if.sink          request,
  dasc_res_if.source        result
);

  cfg_t   cfg;
  logic   s1_valid;
  stage_t s1;
  logic   s1_take;

  dasc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dasc_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .in_item  (request.item),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_take  (s1_take)
  );

  dasc_report u_report (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_take   (s1_take),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_item  (result.item)
  );

endmodule

// ----- sv/dasc_checker.sv -----
// Port-level assertions for the slew controller and their bind to the top level.
module dasc_checker import dasc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      res_valid,
  input logic      res_ready,
  input res_item_t res_item
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("stalled result changed or vanished");

  // A request transfer is followed by a valid result once the pipeline depth has passed.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##3 res_valid)
    else $error("no result after a request transfer");

  // No motor command means zero speed and clockwise.
  a_motor_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.motor_on |-> res_item.motor_speed == '0 && !res_item.motor_ccw)
    else $error("motor fields set without a command");

  // A motor command only comes from a slew that is still running.
  a_motor_slewing: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.motor_on |-> res_item.slewing &&
                                        res_item.status == STATUS_OK)
    else $error("motor command outside a running slew");

endmodule

bind dome_azimuth_slew_controller_core dasc_checker u_dasc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (request.valid),
  .req_ready (request.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_item  (result.item)
);
